@@ sv/stis_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted table interpolation search - shared definitions
// Field widths, stream packing positions, action codes and the widths of the
// probe arithmetic shared by the sequencer and the scaling divider.
// ----------------------------------------------------------------------------
package stis_pkg;

    // configuration and field widths
    localparam int CNT_W       = 11;   // entry_count
    localparam int LOAD_IDX_W  = 10;   // load_index and match_index
    localparam int KEY_IN_W    = 32;   // key_value on the stream
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;
    localparam int IN_KEY_LSB  = LOAD_IDX_W;

    // probe arithmetic
    localparam int POS_W  = 13;        // signed range bounds, -1 .. 2*2047
    localparam int SPAN_W = 11;        // high - low
    localparam int QUOT_W = 12;        // scaled quotient
    localparam int BIT_W  = 4;         // bit counter over SPAN_W bits

    typedef logic signed [POS_W-1:0] t_pos;
    typedef logic [SPAN_W-1:0]       t_span;
    typedef logic [QUOT_W-1:0]       t_quot;

    // action codes carried in tuser
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

endpackage
`default_nettype wire

@@ sv/stis_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scaling divider
// Bit-serial floor(num * span / den) for num <= den. Each span bit takes a
// doubling step and an add step, each followed by one conditional
// subtract of the denominator.
// ----------------------------------------------------------------------------
module stis_div #(
    parameter int KEY_WIDTH = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_start,
    input  wire  [KEY_WIDTH-1:0]          i_num,
    input  wire  [KEY_WIDTH-1:0]          i_den,
    input  wire  stis_pkg::t_span         i_span,
    output logic                          o_done,
    output stis_pkg::t_quot               o_quot
);

    logic                         r_busy, n_busy;
    logic                         r_phase, n_phase;
    logic [stis_pkg::BIT_W-1:0]   r_bit, n_bit;
    logic                         r_done, n_done;
    logic [KEY_WIDTH:0]           r_rem, n_rem;
    logic [KEY_WIDTH-1:0]         r_num, r_den;
    stis_pkg::t_span              r_span;
    stis_pkg::t_quot              r_quot, n_quot;

    logic [KEY_WIDTH:0]           step_val;
    logic                         step_ge;
    stis_pkg::t_quot              quot_base;

    always_comb begin
        if (r_phase) begin
            step_val  = r_rem + (r_span[r_bit] ? {1'b0, r_num} : '0);
            quot_base = r_quot;
        end else begin
            step_val  = {r_rem[KEY_WIDTH-1:0], 1'b0};
            quot_base = {r_quot[stis_pkg::QUOT_W-2:0], 1'b0};
        end
        step_ge = (step_val >= {1'b0, r_den});
    end

    always_comb begin
        n_busy  = r_busy;
        n_phase = r_phase;
        n_bit   = r_bit;
        n_done  = 1'b0;
        n_rem   = r_rem;
        n_quot  = r_quot;
        if (i_start) begin
            n_busy  = 1'b1;
            n_phase = 1'b0;
            n_bit   = stis_pkg::BIT_W'(stis_pkg::SPAN_W - 1);
            n_rem   = '0;
            n_quot  = '0;
        end else if (r_busy) begin
            n_rem   = step_ge ? (step_val - {1'b0, r_den}) : step_val;
            n_quot  = quot_base + stis_pkg::QUOT_W'(step_ge);
            n_phase = !r_phase;
            if (r_phase) begin
                if (r_bit == '0) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_bit   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quot <= n_quot;
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_span <= i_span;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

@@ sv/sorted_table_interpolation_search.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted table interpolation search
// Key table with interpolation search over its first entry_count entries.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser[0] is the action (0 load, 1 search); tdata carries
//   load_index in [9:0] and key_value in [41:10]. A load writes one key and
//   gives no result; a search gives exactly one result on the master stream
//   with found in tuser[0] and match_index in tdata[9:0] (0 on a miss).
//   Config channel: a transfer writes entry_count; always ready. Write it
//   only while no search is in flight.
//   Steps: a load writes one key. A search fetches the two end keys and
//   decides, then repeats probes; each probe runs the bit-serial scaling
//   divider, one bit at a time over the 11-bit span, then the table read
//   of the probed key and the reload of one bound key. The
//   number of probes depends on the key distribution, typically 1 to 4.
//   The table has one read port; each key fetch is a read and a capture step.
//   Reset clears the sequencer and sets entry_count to 1024; table contents
//   are undefined until loaded. A result waits in an output register; while
//   the receiver stalls, the idle block still takes loads and searches, and a
//   finished search holds, taking no input, until the register frees.
// ----------------------------------------------------------------------------
module sorted_table_interpolation_search #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 32
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // slave stream
    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire  [stis_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,   // load_index, key_value
    input  wire  [0:0]                          i_s_axis_tuser,   // action
    // master stream
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    output logic [stis_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,   // match_index
    output logic [0:0]                          o_m_axis_tuser,   // found
    // configuration
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [stis_pkg::CNT_W-1:0]          i_cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD_LV  = 4'd1;
    localparam logic [3:0] S_CAP_LV = 4'd2;
    localparam logic [3:0] S_RD_HV  = 4'd3;
    localparam logic [3:0] S_CAP_HV = 4'd4;
    localparam logic [3:0] S_CHECK  = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_POS    = 4'd7;
    localparam logic [3:0] S_RD_PV  = 4'd8;
    localparam logic [3:0] S_CAP_PV = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0]                     r_state, n_state;
    logic [stis_pkg::CNT_W-1:0]     r_cfg;
    logic [stis_pkg::CNT_W-1:0]     r_n, n_n;
    logic [KEY_WIDTH-1:0]           r_key, n_key;
    stis_pkg::t_pos                 r_low, n_low;
    stis_pkg::t_pos                 r_high, n_high;
    stis_pkg::t_pos                 r_pos, n_pos;
    logic [KEY_WIDTH-1:0]           r_lowval, n_lowval;
    logic [KEY_WIDTH-1:0]           r_highval, n_highval;
    logic                           r_init, n_init;
    logic                           r_res_found, n_res_found;
    logic [stis_pkg::LOAD_IDX_W-1:0] r_res_idx, n_res_idx;
    logic                           r_out_valid, n_out_valid;
    logic                           r_out_found;
    logic [stis_pkg::LOAD_IDX_W-1:0] r_out_idx;

    logic                           r_div_start, n_div_start;
    logic [KEY_WIDTH-1:0]           r_div_num, n_div_num;
    logic [KEY_WIDTH-1:0]           r_div_den, n_div_den;
    stis_pkg::t_span                r_div_span, n_div_span;
    logic                           div_done;
    stis_pkg::t_quot                div_quot;

    logic [KEY_WIDTH-1:0]           r_mem [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0]           r_rd_data;
    logic [AW-1:0]                  rd_addr;
    logic                           wr_en;

    logic                           in_xfer, load_xfer, search_xfer;
    logic [stis_pkg::LOAD_IDX_W-1:0] in_idx;
    logic [KEY_WIDTH-1:0]           in_key;
    logic [stis_pkg::CNT_W-1:0]     n_active;
    stis_pkg::t_pos                 n_bound;
    stis_pkg::t_pos                 pos_sum, pos_inc, pos_dec;
    logic                           in_range;
    logic                           done_move;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;

    assign in_xfer     = i_s_axis_tvalid && o_s_axis_tready;
    assign load_xfer   = in_xfer && (i_s_axis_tuser[0] == stis_pkg::ACT_LOAD);
    assign search_xfer = in_xfer && (i_s_axis_tuser[0] == stis_pkg::ACT_SEARCH);
    assign in_idx      = i_s_axis_tdata[stis_pkg::LOAD_IDX_W-1:0];
    assign in_key      = KEY_WIDTH'(i_s_axis_tdata[stis_pkg::IN_KEY_LSB +:
                                                   stis_pkg::KEY_IN_W]);
    // drop loads aimed past the table
    assign wr_en       = load_xfer && (32'(in_idx) < TABLE_DEPTH);

    assign n_active = (32'(r_cfg) > TABLE_DEPTH) ? stis_pkg::CNT_W'(TABLE_DEPTH) : r_cfg;
    assign n_bound  = $signed({2'b00, r_n});
    assign pos_sum  = r_low + $signed({1'b0, div_quot});
    assign pos_inc  = r_pos + stis_pkg::POS_W'(1);
    assign pos_dec  = r_pos - stis_pkg::POS_W'(1);
    assign in_range = (r_low <= r_high) && (r_key >= r_lowval) && (r_key <= r_highval);
    assign done_move = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);

    always_comb begin
        case (r_state)
            S_RD_HV: rd_addr = AW'($unsigned(r_high));
            S_RD_PV: rd_addr = AW'($unsigned(r_pos));
            default: rd_addr = AW'($unsigned(r_low));
        endcase
    end

    // key table: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[AW'(in_idx)] <= in_key;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_key       = r_key;
        n_low       = r_low;
        n_high      = r_high;
        n_pos       = r_pos;
        n_lowval    = r_lowval;
        n_highval   = r_highval;
        n_init      = r_init;
        n_res_found = r_res_found;
        n_res_idx   = r_res_idx;
        n_div_start = 1'b0;
        n_div_num   = r_div_num;
        n_div_den   = r_div_den;
        n_div_span  = r_div_span;
        case (r_state)
            S_IDLE: begin
                if (search_xfer) begin
                    n_n    = n_active;
                    n_key  = in_key;
                    n_low  = '0;
                    n_high = $signed({2'b00, n_active}) - stis_pkg::POS_W'(1);
                    n_init = 1'b1;
                    if (n_active == '0) begin
                        n_res_found = 1'b0;
                        n_res_idx   = '0;
                        n_state     = S_DONE;
                    end else begin
                        n_state = S_RD_LV;
                    end
                end
            end
            S_RD_LV:  n_state = S_CAP_LV;
            S_CAP_LV: begin
                n_lowval = r_rd_data;
                n_state  = r_init ? S_RD_HV : S_CHECK;
            end
            S_RD_HV:  n_state = S_CAP_HV;
            S_CAP_HV: begin
                n_highval = r_rd_data;
                n_init    = 1'b0;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                if (!in_range) begin
                    n_res_found = 1'b0;
                    n_res_idx   = '0;
                    n_state     = S_DONE;
                end else if ((r_low == r_high) || (r_lowval == r_highval)) begin
                    // single entry or flat range: decide on the low key
                    n_res_found = (r_lowval == r_key);
                    n_res_idx   = (r_lowval == r_key) ?
                                  r_low[stis_pkg::LOAD_IDX_W-1:0] : '0;
                    n_state     = S_DONE;
                end else begin
                    n_div_start = 1'b1;
                    n_div_num   = r_key - r_lowval;
                    n_div_den   = r_highval - r_lowval;
                    n_div_span  = stis_pkg::SPAN_W'($unsigned(r_high - r_low));
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_POS;
                end
            end
            S_POS: begin
                if (($signed({1'b0, div_quot}) >= n_bound) || (pos_sum >= n_bound)) begin
                    n_res_found = 1'b0;
                    n_res_idx   = '0;
                    n_state     = S_DONE;
                end else begin
                    n_pos   = pos_sum;
                    n_state = S_RD_PV;
                end
            end
            S_RD_PV:  n_state = S_CAP_PV;
            S_CAP_PV: begin
                if (r_rd_data == r_key) begin
                    n_res_found = 1'b1;
                    n_res_idx   = r_pos[stis_pkg::LOAD_IDX_W-1:0];
                    n_state     = S_DONE;
                end else if (r_rd_data < r_key) begin
                    n_low   = pos_inc;
                    n_state = (pos_inc < n_bound) ? S_RD_LV : S_CHECK;
                end else begin
                    n_high  = pos_dec;
                    n_state = (r_pos != '0) ? S_RD_HV : S_CHECK;
                end
            end
            S_DONE: begin
                if (done_move) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (done_move) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= stis_pkg::CNT_W'(1024);
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
            r_init      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_div_start <= n_div_start;
            r_init      <= n_init;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_key       <= n_key;
        r_low       <= n_low;
        r_high      <= n_high;
        r_pos       <= n_pos;
        r_lowval    <= n_lowval;
        r_highval   <= n_highval;
        r_res_found <= n_res_found;
        r_res_idx   <= n_res_idx;
        r_div_num   <= n_div_num;
        r_div_den   <= n_div_den;
        r_div_span  <= n_div_span;
        if (done_move) begin
            r_out_found <= r_res_found;
            r_out_idx   <= r_res_idx;
        end
    end

    stis_div #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .i_span  (r_div_span),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_found;
    assign o_m_axis_tdata  = stis_pkg::OUT_TDATA_W'(r_out_idx);

    // a miss always reports index zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata == '0)
        else $error("miss reported with a non-zero index");

    // a load never leaves the idle state
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_xfer |=> r_state == S_IDLE)
        else $error("load transfer left the idle state");

    // the block stops taking items once a search starts
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        search_xfer |=> !o_s_axis_tready)
        else $error("ready stayed high after a search transfer");

    // probes stay inside the active entries
    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RD_PV |-> (r_pos >= 0) && (r_pos < n_bound))
        else $error("probe outside the active table");

endmodule
`default_nettype wire
